// File: src/sfr_pkg.sv
package sfr_pkg;

	// Frame layout and checksum
	localparam int unsigned FRAME_HELD = 4;
	localparam logic [2:0] FRAME_LAST_POS = 3'd4;
	localparam logic [8:0] CHECK_SUM = 9'd255;

	// Opcodes
	localparam logic [7:0] OP_KEY = 8'hB1;
	localparam logic [7:0] OP_POWER = 8'hD4;
	localparam logic [7:0] OP_BATTERY = 8'hB4;

	// Key and battery decoding
	localparam logic [7:0] KEY_PRESS_CODE = 8'h2B;
	localparam logic [7:0] BATTERY_MASK = 8'h1F;
	localparam int unsigned KEY_SLOTS = 40;

	// Reply bytes
	localparam logic [7:0] ACK_HEAD = 8'hA2;
	localparam logic [7:0] ACK_TAIL = 8'h5D;
	localparam logic [7:0] NACK_HEAD = 8'hA3;
	localparam logic [7:0] NACK_TAIL = 8'h5C;
	localparam logic [2:0] REPLY_LAST = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_TX = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd1;
	localparam logic [1:0] KIND_POWER = 2'd2;

	// Field widths
	localparam int unsigned MASK_W = 40;
	localparam logic [MASK_W-1:0] MASK_RESET = 40'hFF00FF00FF;
	localparam int unsigned TDATA_W = 24;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// One checked frame, as handed from front to back
	typedef struct packed {
		logic       good;
		logic [1:0] ev_n;
		logic       is_power;
		logic [5:0] key_index;
		logic       key_pressed;
		logic [4:0] battery;
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: src/sfr_front.sv
module sfr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	input  logic                        cfg_we,
	input  logic [sfr_pkg::MASK_W-1:0]  cfg_wdata,
	input  sfr_pkg::q_status_t          q_st,
	output logic                        q_push,
	output sfr_pkg::cmd_t               q_cmd
);

	logic [2:0]                 byte_count_q;
	logic [7:0]                 frame_q [sfr_pkg::FRAME_HELD];
	logic [4:0]                 battery_q;
	logic [sfr_pkg::MASK_W-1:0] mask_q;
	logic                       accept;
	logic                       at_end;
	logic [7:0]                 op;
	logic [7:0]                 idx;
	logic                       good;
	logic                       key_ok;

	// Stall only when a frame completes and the queue has no room
	assign at_end = (byte_count_q == sfr_pkg::FRAME_LAST_POS);
	assign s_tready = !(at_end && q_st.full);
	assign accept = s_tvalid && s_tready;
	assign q_push = accept && at_end;

	// Check the frame and classify it
	always_comb begin
		op = frame_q[0];
		idx = frame_q[1];
		good = ({1'b0, op} + {1'b0, s_tdata}) == sfr_pkg::CHECK_SUM;
		key_ok = (op == sfr_pkg::OP_KEY)
			&& ({1'b0, idx} < 9'(sfr_pkg::KEY_SLOTS))
			&& ({1'b0, idx} < 9'(sfr_pkg::MASK_W))
			&& mask_q[idx[5:0]];
		q_cmd = '0;
		q_cmd.good = good;
		q_cmd.battery = battery_q;
		if (good) begin
			priority if (key_ok) begin
				q_cmd.ev_n = 2'd1;
				q_cmd.key_index = idx[5:0];
				q_cmd.key_pressed = (frame_q[2] == sfr_pkg::KEY_PRESS_CODE);
			end else if (op == sfr_pkg::OP_POWER) begin
				q_cmd.ev_n = 2'd2;
				q_cmd.is_power = 1'b1;
			end else if (op == sfr_pkg::OP_BATTERY) begin
				q_cmd.battery = 5'(frame_q[2] & sfr_pkg::BATTERY_MASK);
			end else begin
				// Masked or out-of-range key, or other opcode: reply only
				q_cmd.ev_n = 2'd0;
			end
		end
	end

	// Count bytes and keep the battery level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			battery_q <= '0;
		end else if (accept) begin
			if (at_end) begin
				byte_count_q <= '0;
				battery_q <= q_cmd.battery;
			end else begin
				byte_count_q <= byte_count_q + 3'd1;
			end
		end
	end

	// Hold the first four bytes of the frame
	always_ff @(posedge clk) begin
		if (accept && !at_end) begin
			frame_q[byte_count_q[1:0]] <= s_tdata;
		end
	end

	// Key enable mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= sfr_pkg::MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

endmodule

// File: src/sfr_queue.sv
module sfr_queue #(
	parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sfr_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output sfr_pkg::cmd_t      head,
	output sfr_pkg::q_status_t st
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sfr_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign st.full = (count_q == CNT_W'(DEPTH));
	assign st.empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store an entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: src/sfr_back.sv
module sfr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfr_pkg::cmd_t               q_head,
	input  sfr_pkg::q_status_t          q_st,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sfr_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast
);

	logic [2:0] step_q;
	logic       m_tvalid_q;
	logic [1:0] kind_q;
	logic [7:0] tx_q;
	logic [5:0] key_index_q;
	logic       pressed_q;
	logic [4:0] battery_q;
	logic       last_q;

	logic [2:0] ev_w;
	logic [2:0] rep_pos;
	logic       is_evt;
	logic       is_last;
	logic       advance;
	logic       load;
	logic [1:0] kind_d;
	logic [7:0] tx_d;
	logic [5:0] key_index_d;
	logic       pressed_d;

	// Work out the result at the current step of the head frame
	always_comb begin
		ev_w = {1'b0, q_head.ev_n};
		is_evt = step_q < ev_w;
		rep_pos = step_q - ev_w;
		is_last = (rep_pos == sfr_pkg::REPLY_LAST);
		kind_d = sfr_pkg::KIND_TX;
		tx_d = '0;
		key_index_d = '0;
		pressed_d = 1'b0;
		if (is_evt) begin
			if (q_head.is_power) begin
				kind_d = sfr_pkg::KIND_POWER;
				pressed_d = (step_q == 3'd0);
			end else begin
				kind_d = sfr_pkg::KIND_KEY;
				key_index_d = q_head.key_index;
				pressed_d = q_head.key_pressed;
			end
		end else begin
			priority if (rep_pos == 3'd0) begin
				tx_d = q_head.good ? sfr_pkg::ACK_HEAD : sfr_pkg::NACK_HEAD;
			end else if (rep_pos == sfr_pkg::REPLY_LAST) begin
				tx_d = q_head.good ? sfr_pkg::ACK_TAIL : sfr_pkg::NACK_TAIL;
			end else begin
				tx_d = '0;
			end
		end
	end

	assign advance = !m_tvalid_q || m_tready;
	assign load = advance && !q_st.empty;
	assign q_pop = load && is_last;

	// Step through the frame's results and fill the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				m_tvalid_q <= !q_st.empty;
			end
			if (load) begin
				step_q <= is_last ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			tx_q <= tx_d;
			key_index_q <= key_index_d;
			pressed_q <= pressed_d;
			battery_q <= q_head.battery;
			last_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0, battery_q, pressed_q, key_index_q, tx_q};
	assign m_tuser = kind_q;
	assign m_tlast = last_q;

endmodule

// File: src/subcpu_frame_receiver.sv
// One byte is taken per cycle, save when a finished frame meets a full queue; a frame
// gives 5 to 7 results, one per cycle while m_tready allows, set by the result
// sequencer; up to QUEUE_DEPTH checked frames wait in the queue between the two.
// Reset: arst_n clears the byte count, battery level, queue and output register
// and restores the key enable mask to its default.
module subcpu_frame_receiver #(
	parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sfr_pkg::TDATA_W-1:0] m_tdata,   // [7:0] tx_byte, [13:8] key_index,
	                                               // [14] pressed, [19:15] battery
	output logic [1:0]                  m_tuser,   // [1:0] kind
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [sfr_pkg::MASK_W-1:0]  cfg_wdata
);

	sfr_pkg::cmd_t      push_cmd;
	sfr_pkg::cmd_t      head_cmd;
	sfr_pkg::q_status_t q_st;
	logic               q_push;
	logic               q_pop;

	sfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_st      (q_st),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.st       (q_st)
	);

	sfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_head   (head_cmd),
		.q_st     (q_st),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	// The last result of a frame is always the closing reply byte
	a_last_is_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == sfr_pkg::KIND_TX)
		else $error("frame ended on an event result");

	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_st.full)
		else $error("queue overflow");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_st.empty)
		else $error("queue underflow");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;
	import sfr_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_STALL    = 400;
	localparam int PHASE_BYTES   = 145;
	localparam int SHOWN_ERRORS  = 10;

	// One result transfer, split into its fields
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx;
		logic [5:0] key;
		logic       pressed;
		logic [4:0] level;
		logic       last;
		logic [3:0] pad;
	} link_result_t;

	// Frame decoder mirror plus the store of results still owed by the block
	class frame_checker;
		logic [MASK_W-1:0] key_mask;
		logic [7:0]        held [FRAME_HELD];
		int                held_n;
		logic [4:0]        level;
		link_result_t      pending [$];
		int                mismatches;
		int                checked;
		int                frames;
		int                key_events;
		int                power_events;
		int                nacks;

		function new();
			key_mask = MASK_RESET;
			held_n = 0;
			level = '0;
			mismatches = 0;
			checked = 0;
			frames = 0;
			key_events = 0;
			power_events = 0;
			nacks = 0;
		endfunction

		function void set_mask(logic [MASK_W-1:0] value);
			key_mask = value;
		endfunction

		// Hold the first four bytes; on the fifth decode the frame and queue its results
		function void take_byte(logic [7:0] b);
			link_result_t fresh [$];
			link_result_t r;
			logic         good;
			if (held_n < FRAME_HELD) begin
				held[held_n] = b;
				held_n++;
				return;
			end
			held_n = 0;
			frames++;
			good = ({1'b0, held[0]} + {1'b0, b}) == CHECK_SUM;
			r = '0;
			if (good) begin
				case (held[0])
					OP_KEY: begin
						if (held[1] < KEY_SLOTS && key_mask[held[1][5:0]]) begin
							r.kind = KIND_KEY;
							r.key = held[1][5:0];
							r.pressed = (held[2] == KEY_PRESS_CODE);
							fresh.push_back(r);
							key_events++;
						end
					end
					OP_POWER: begin
						r.kind = KIND_POWER;
						r.pressed = 1'b1;
						fresh.push_back(r);
						r.pressed = 1'b0;
						fresh.push_back(r);
						power_events++;
					end
					OP_BATTERY: level = 5'(held[2] & BATTERY_MASK);
					default: ;
				endcase
			end else begin
				nacks++;
			end
			// Reply bytes follow any events
			r = '0;
			r.kind = KIND_TX;
			r.tx = good ? ACK_HEAD : NACK_HEAD;
			fresh.push_back(r);
			r.tx = '0;
			repeat (3) fresh.push_back(r);
			r.tx = good ? ACK_TAIL : NACK_TAIL;
			fresh.push_back(r);
			foreach (fresh[i]) begin
				r = fresh[i];
				r.level = level;
				r.last = (i == fresh.size() - 1);
				pending.push_back(r);
			end
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(link_result_t got);
			link_result_t want;
			if (pending.size() == 0) begin
				if (mismatches < SHOWN_ERRORS)
					$display("unexpected result: kind %0d tx %02h key %0d pressed %0d level %0d last %0d",
						got.kind, got.tx, got.key, got.pressed, got.level, got.last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.kind !== want.kind || got.tx !== want.tx || got.key !== want.key ||
					got.pressed !== want.pressed || got.level !== want.level ||
					got.last !== want.last || got.pad !== want.pad) begin
				if (mismatches < SHOWN_ERRORS) begin
					$display("mismatch on result %0d", checked);
					$display("  expected kind %0d tx %02h key %0d pressed %0d level %0d last %0d pad %0h",
						want.kind, want.tx, want.key, want.pressed, want.level, want.last, want.pad);
					$display("  actual   kind %0d tx %02h key %0d pressed %0d level %0d last %0d pad %0h",
						got.kind, got.tx, got.key, got.pressed, got.level, got.last, got.pad);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [MASK_W-1:0]   cfg_wdata = '0;

	frame_checker board;
	int send_gap_pct = 0;
	int take_gap_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int cycle_count = 0;

	subcpu_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	// Check each result transfer, then pick the next ready level
	always @(posedge clk) begin
		link_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.tx = m_tdata[7:0];
			got.key = m_tdata[13:8];
			got.pressed = m_tdata[14];
			got.level = m_tdata[19:15];
			got.last = m_tlast;
			got.pad = m_tdata[23:20];
			board.check_result(got);
		end
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= take_gap_pct);
		end
	end

	// Offer one byte, with random gaps, until it is transferred
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		board.take_byte(b);
		bytes_sent++;
	endtask

	// Mostly well-formed frames with random content, a few with a bad checksum
	task automatic send_random_frame();
		logic [7:0] op;
		logic [7:0] check;
		int         pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			op = OP_KEY;
		else if (pick < 6)
			op = OP_POWER;
		else if (pick < 8)
			op = OP_BATTERY;
		else
			op = 8'($urandom);
		check = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'hFF - op;
		send_byte(op);
		send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 45)));
		send_byte($urandom_range(0, 1) ? KEY_PRESS_CODE : 8'($urandom));
		send_byte(8'($urandom));
		send_byte(check);
	endtask

	// Drop the offer and wait for the block to drain completely
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_mask(value);
	endtask

	// Random traffic: frames, with stray bytes now and then knocking the framing out
	task automatic run_phase(input int n_bytes, input int stall_at);
		int first;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes) begin
			if (stall_at > 0 && bytes_sent - first >= stall_at) begin
				hold_req = LONG_STALL;
				stall_at = 0;
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else begin
				while (bytes_sent % 5 != 0) send_byte(8'($urandom));
				send_random_frame();
			end
		end
		while (bytes_sent % 5 != 0) send_byte(8'($urandom));
		settle();
	endtask

	initial begin
		logic [7:0]        directed [25];
		logic [MASK_W-1:0] mask_val;
		board = new();
		// Top key, power, full battery, index past the table, bad checksum
		directed = '{
			OP_KEY, 8'd39, KEY_PRESS_CODE, 8'h00, 8'hFF - OP_KEY,
			OP_POWER, 8'hFF, 8'h00, 8'hFF, 8'hFF - OP_POWER,
			OP_BATTERY, 8'h00, 8'hFF, 8'h00, 8'hFF - OP_BATTERY,
			OP_KEY, 8'd40, KEY_PRESS_CODE, 8'h00, 8'hFF - OP_KEY,
			8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_byte(directed[i]);
		settle();

		write_mask('1);
		send_gap_pct = 22;
		take_gap_pct = 76;
		run_phase(PHASE_BYTES, 0);

		write_mask('0);
		send_gap_pct = 76;
		take_gap_pct = 22;
		run_phase(PHASE_BYTES, 0);

		mask_val = {8'($urandom), $urandom};
		write_mask(mask_val);
		send_gap_pct = 0;
		take_gap_pct = 0;
		run_phase(PHASE_BYTES, 40);

		$display("%0d bytes in %0d frames, %0d results checked: %0d key events, %0d power pairs, %0d bad frames",
			bytes_sent, board.frames, board.checked, board.key_events, board.power_events,
			board.nacks);
		$display("key masks: default, all set, all clear, random; one %0d-cycle output stall",
			LONG_STALL);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results outstanding", board.mismatches,
				board.pending.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
